### design/itds_pkg.sv
// Package for the integer to decimal text converter.
// Holds the widths, character codes, word types and the double-dabble step.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package itds_pkg;

  localparam int MAX_CHARS  = 12;
  localparam int TEXT_CAP   = 11;
  localparam int N_DIGITS   = 10;
  localparam int VAL_W      = 32;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = $clog2(TEXT_CAP + 1);
  localparam int IDX_W      = $clog2(N_DIGITS);
  localparam int DD_STAGES  = 4;
  localparam int DD_STEPS   = VAL_W / DD_STAGES;
  localparam int BCD_W      = N_DIGITS * DIGIT_W;
  localparam int SH_W       = BCD_W + VAL_W;

  // Longest text that is sent, in characters.
  localparam int TEXT_LIMIT = (MAX_CHARS - 1 > TEXT_CAP) ? TEXT_CAP :
                              ((MAX_CHARS - 1 < 1) ? 1 : MAX_CHARS - 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

  typedef struct packed {
    logic            neg;
    logic [SH_W-1:0] sh;
  } dd_word_t;

  typedef logic [TEXT_CAP-1:0][CHAR_W-1:0] text_t;

  typedef struct packed {
    text_t            text;
    logic [CNT_W-1:0] len;
  } fmt_t;

  // One double-dabble step: correct every BCD digit above four, then shift.
  function automatic logic [SH_W-1:0] dd_step(input logic [SH_W-1:0] sh);
    logic [SH_W-1:0] t;
    t = sh;
    for (int i = 0; i < N_DIGITS; i++) begin
      if (t[VAL_W + DIGIT_W*i +: DIGIT_W] >= DIGIT_W'(5)) begin
        t[VAL_W + DIGIT_W*i +: DIGIT_W] = t[VAL_W + DIGIT_W*i +: DIGIT_W] + DIGIT_W'(3);
      end
    end
    return {t[SH_W-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

### design/itds_in_if.sv
// Input channel of the converter: one signed 32-bit value per word.
// Depends on itds_pkg for the value width.
`default_nettype none

interface itds_in_if
  import itds_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### design/itds_out_if.sv
// Output channel of the converter: one ASCII character per word, with a last flag.
// Depends on itds_pkg for the character width.
`default_nettype none

interface itds_out_if
  import itds_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### design/int_to_decimal_string_core.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Depends on itds_pkg, both channel interfaces and the three stage modules.
//
// Each accepted value is sent back as its decimal text, one character per
// output word, most significant character first; a negative value is led by
// '-', zero gives a single '0', and the most negative value is converted from
// its unsigned magnitude. The final character of each text has last set. The
// value runs through a pipeline of six registered stages (magnitude, four
// binary to BCD stages of eight shift steps each, and formatting) before it
// reaches the serialiser. The serialiser sends one word a cycle while the
// output is not stalled, and a text has one to eleven characters, eleven at
// most for a full-length negative number. The sustained rate is therefore
// set by the output port. Back-pressure travels up the pipeline stage by
// stage, and the stages keep filling while the serialiser is busy, so
// several values can be in flight at once.
`default_nettype none

module int_to_decimal_string_core
  import itds_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itds_in_if.sink    in_i,
  itds_out_if.source out_o
);

  // Stage zero: sign and magnitude.
  logic     mag_valid_q;
  dd_word_t mag_word_d, mag_word_q;
  logic     [VAL_W-1:0] raw;

  // Binary to BCD chain; index zero is the magnitude stage output.
  logic     dd_valid [DD_STAGES+1];
  logic     dd_ready [DD_STAGES+1];
  dd_word_t dd_word  [DD_STAGES+1];

  logic fmt_valid;
  logic fmt_ready;
  fmt_t fmt_word;

  assign raw        = VAL_W'(in_i.value);
  assign in_i.ready = !mag_valid_q || dd_ready[0];

  always_comb begin
    mag_word_d.neg = raw[VAL_W-1];
    mag_word_d.sh  = {BCD_W'(0), (raw[VAL_W-1] ? (VAL_W'(0) - raw) : raw)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      mag_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      mag_word_q <= mag_word_d;
    end
  end

  assign dd_valid[0] = mag_valid_q;
  assign dd_word[0]  = mag_word_q;

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    itds_dd_stage u_dd (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dd_valid[g]),
      .ready_o (dd_ready[g]),
      .word_i  (dd_word[g]),
      .valid_o (dd_valid[g+1]),
      .ready_i (dd_ready[g+1]),
      .word_o  (dd_word[g+1])
    );
  end

  itds_fmt_stage u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dd_valid[DD_STAGES]),
    .ready_o (dd_ready[DD_STAGES]),
    .word_i  (dd_word[DD_STAGES]),
    .valid_o (fmt_valid),
    .ready_i (fmt_ready),
    .fmt_o   (fmt_word)
  );

  itds_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fmt_valid),
    .ready_o (fmt_ready),
    .fmt_i   (fmt_word),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### design/itds_dd_stage.sv
// One registered stage of the binary to BCD pipeline, doing a quarter of the shifts.
// Depends on itds_pkg for the word type and the double-dabble step.
`default_nettype none

module itds_dd_stage
  import itds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire dd_word_t word_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output dd_word_t      word_o
);

  logic     valid_q;
  dd_word_t word_d, word_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    word_d = word_i;
    for (int s = 0; s < DD_STEPS; s++) begin
      word_d.sh = dd_step(word_d.sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

### design/itds_fmt_stage.sv
// Formatting stage: drops leading zeros, places the sign and builds the text.
// Depends on itds_pkg for the word and text types.
`default_nettype none

module itds_fmt_stage
  import itds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire dd_word_t word_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output fmt_t          fmt_o
);

  logic                               valid_q;
  fmt_t                               fmt_d, fmt_q;
  logic [N_DIGITS-1:0][DIGIT_W-1:0]   digits;
  logic [CNT_W-1:0]                   n_dig;
  logic [CNT_W-1:0]                   full_len;
  logic [CNT_W-1:0]                   pos;
  logic [CNT_W-1:0]                   didx;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign fmt_o   = fmt_q;
  assign digits  = word_i.sh[SH_W-1:VAL_W];

  always_comb begin
    n_dig = CNT_W'(1);
    for (int i = 0; i < N_DIGITS; i++) begin
      if (digits[i] != '0) begin
        n_dig = CNT_W'(i + 1);
      end
    end
    full_len = n_dig + CNT_W'(word_i.neg);
    fmt_d.len = (full_len > CNT_W'(TEXT_LIMIT)) ? CNT_W'(TEXT_LIMIT) : full_len;
    pos  = '0;
    didx = '0;
    for (int k = 0; k < TEXT_CAP; k++) begin
      fmt_d.text[k] = CHAR_ZERO;
      pos = CNT_W'(k) - CNT_W'(word_i.neg);
      didx = n_dig - CNT_W'(1) - pos;
      if (word_i.neg && k == 0) begin
        fmt_d.text[k] = CHAR_MINUS;
      end else if (pos < n_dig && didx < CNT_W'(N_DIGITS)) begin
        fmt_d.text[k] = CHAR_ZERO | CHAR_W'(digits[didx[IDX_W-1:0]]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      fmt_q <= fmt_d;
    end
  end

endmodule

`default_nettype wire

### design/itds_serial.sv
// Output serialiser: sends the text of one value a character per word.
// Depends on itds_pkg and the output channel interface.
`default_nettype none

module itds_serial
  import itds_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire fmt_t  fmt_i,
  itds_out_if.source out_o
);

  text_t            text_d, text_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             take;

  assign take    = out_o.valid && out_o.ready;
  assign ready_o = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_o.ready);

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.character = text_q[0];
  assign out_o.last      = (cnt_q == CNT_W'(1));

  always_comb begin
    text_d = text_q;
    cnt_d  = cnt_q;
    if (take) begin
      cnt_d = cnt_q - CNT_W'(1);
      for (int k = 0; k < TEXT_CAP - 1; k++) begin
        text_d[k] = text_q[k+1];
      end
    end
    if (ready_o && valid_i) begin
      text_d = fmt_i.text;
      cnt_d  = fmt_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_q <= text_d;
  end

endmodule

`default_nettype wire
